### sv/tcphp_pkg.sv
package tcphp_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WATCH_PORT_A  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WATCH_PORT_B  = 2'd2;

	localparam logic [7:0]  RST_PAYLOAD_LIMIT = 8'd100;
	localparam logic [15:0] RST_WATCH_PORT_A  = 16'd80;
	localparam logic [15:0] RST_WATCH_PORT_B  = 16'd443;

	// Protocol constants.
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  IP_PROTO_TCP  = 8'd6;
	localparam int          ETH_HDR_BYTES = 14;
	localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

	// Printable range and the substitute for anything outside it.
	localparam logic [7:0] CHAR_LO  = 8'd32;
	localparam logic [7:0] CHAR_HI  = 8'd126;
	localparam logic [7:0] CHAR_DOT = 8'd46;

	typedef enum logic [1:0] {
		PH_HEADERS = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_REJECT  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_END    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_beat_t;

	typedef struct packed {
		kind_t       record_kind;
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  payload_char;
		logic        last_of_frame;
	} out_beat_t;

	typedef struct packed {
		logic [7:0]  payload_limit;
		logic [15:0] watch_port_a;
		logic [15:0] watch_port_b;
	} cfg_t;

	typedef struct packed {
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} hdr_t;

	// What one accepted byte produces: a header record or a payload
	// character (never both), and possibly a frame end marker after it.
	typedef struct packed {
		logic       hdr;
		logic       chr;
		logic       eom;
		logic [7:0] pchar;
	} parse_res_t;

endpackage

### sv/tcphp_in_if.sv
interface tcphp_in_if import tcphp_pkg::*; ();
	logic     valid;
	logic     ready;
	in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/tcphp_out_if.sv
interface tcphp_out_if import tcphp_pkg::*; ();
	logic      valid;
	logic      ready;
	out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/tcphp_parser.sv
module tcphp_parser import tcphp_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  in_beat_t   beat,
	input  cfg_t       cfg,
	output parse_res_t res,
	output hdr_t       hdr
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES);
	localparam int CW    = (POS_W > 8) ? POS_W : 8;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);

	// Byte offsets within the frame; the last two are relative to the TCP header.
	localparam logic [CW-1:0] P_SMAC     = CW'(6);
	localparam logic [CW-1:0] P_ETH_HI   = CW'(12);
	localparam logic [CW-1:0] P_ETH_LO   = CW'(13);
	localparam logic [CW-1:0] P_VER_IHL  = CW'(14);
	localparam logic [CW-1:0] P_PROTO    = CW'(23);
	localparam logic [CW-1:0] P_SIP      = CW'(26);
	localparam logic [CW-1:0] P_DIP      = CW'(30);
	localparam logic [CW-1:0] P_IP_END   = CW'(34);
	localparam logic [CW-1:0] P_ETH_END  = CW'(ETH_HDR_BYTES);
	localparam logic [CW-1:0] TCP_PORTS  = CW'(4);
	localparam logic [CW-1:0] TCP_DOFF   = CW'(12);

	logic [POS_W-1:0] pos_q, pos_d;
	phase_t           phase_q, phase_d;
	logic [7:0]       eth_hi_q, eth_hi_d;
	logic [3:0]       ihl_q, ihl_d;
	logic [3:0]       doff_q, doff_d;
	logic [7:0]       cnt_q, cnt_d;
	logic [47:0]      dmac_q, dmac_d;
	logic [47:0]      smac_q, smac_d;
	logic [31:0]      sip_q, sip_d;
	logic [31:0]      dip_q, dip_d;
	logic [31:0]      ports_q, ports_d;

	logic [CW-1:0] p;
	logic [CW-1:0] tcp_base;
	logic [CW-1:0] tcp_end;
	logic [7:0]    b;
	logic          port_hit;

	assign p        = CW'(pos_q);
	assign b        = beat.data_byte;
	assign tcp_base = P_ETH_END + CW'({ihl_q, 2'b00});
	assign tcp_end  = tcp_base + CW'({doff_q, 2'b00}) - CW'(1);
	assign port_hit = (ports_q[15:0] == cfg.watch_port_a) ||
		(ports_q[15:0] == cfg.watch_port_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADERS;
			eth_hi_q <= '0;
			ihl_q    <= '0;
			doff_q   <= '0;
			cnt_q    <= '0;
			dmac_q   <= '0;
			smac_q   <= '0;
			sip_q    <= '0;
			dip_q    <= '0;
			ports_q  <= '0;
		end else begin
			pos_q    <= pos_d;
			phase_q  <= phase_d;
			eth_hi_q <= eth_hi_d;
			ihl_q    <= ihl_d;
			doff_q   <= doff_d;
			cnt_q    <= cnt_d;
			dmac_q   <= dmac_d;
			smac_q   <= smac_d;
			sip_q    <= sip_d;
			dip_q    <= dip_d;
			ports_q  <= ports_d;
		end
	end

	always_comb begin
		pos_d    = pos_q;
		phase_d  = phase_q;
		eth_hi_d = eth_hi_q;
		ihl_d    = ihl_q;
		doff_d   = doff_q;
		cnt_d    = cnt_q;
		dmac_d   = dmac_q;
		smac_d   = smac_q;
		sip_d    = sip_q;
		dip_d    = dip_q;
		ports_d  = ports_q;
		res      = '0;
		if (fire) begin
			case (phase_q)
				PH_HEADERS: begin
					if (p < P_SMAC) begin
						dmac_d = {dmac_q[39:0], b};
					end else if (p < P_ETH_HI) begin
						smac_d = {smac_q[39:0], b};
					end else if (p == P_ETH_HI) begin
						eth_hi_d = b;
					end else if (p == P_ETH_LO) begin
						if ({eth_hi_q, b} != ETH_TYPE_IPV4) begin
							phase_d = PH_REJECT;
						end
					end else if (p == P_VER_IHL) begin
						if (b[3:0] < MIN_HDR_WORDS) begin
							phase_d = PH_REJECT;
						end else begin
							ihl_d = b[3:0];
						end
					end else if (p == P_PROTO) begin
						if (b != IP_PROTO_TCP) begin
							phase_d = PH_REJECT;
						end
					end else if (p >= P_SIP && p < P_DIP) begin
						sip_d = {sip_q[23:0], b};
					end else if (p >= P_DIP && p < P_IP_END) begin
						dip_d = {dip_q[23:0], b};
					end
					// The TCP header sits after any IP options.
					if (phase_d == PH_HEADERS && p >= P_IP_END && ihl_q != '0) begin
						if (p >= tcp_base && p < tcp_base + TCP_PORTS) begin
							ports_d = {ports_q[23:0], b};
						end else if (p == tcp_base + TCP_DOFF) begin
							if (b[7:4] < MIN_HDR_WORDS) begin
								phase_d = PH_REJECT;
							end else begin
								doff_d = b[7:4];
							end
						end else if (doff_q != '0 && p == tcp_end) begin
							res.hdr = 1'b1;
							phase_d = PH_PAYLOAD;
						end
					end
					// Headers still incomplete when the position saturates.
					if (phase_d == PH_HEADERS && pos_q == POS_LAST) begin
						phase_d = PH_REJECT;
					end
				end
				PH_PAYLOAD: begin
					if (port_hit && cnt_q < cfg.payload_limit) begin
						res.chr = 1'b1;
						cnt_d   = cnt_q + 8'd1;
					end
				end
				default: begin
				end
			endcase
			res.pchar = (b inside {[CHAR_LO:CHAR_HI]}) ? b : CHAR_DOT;
			if (beat.end_of_frame) begin
				res.eom  = (phase_d == PH_PAYLOAD);
				pos_d    = '0;
				phase_d  = PH_HEADERS;
				eth_hi_d = '0;
				ihl_d    = '0;
				doff_d   = '0;
				cnt_d    = '0;
			end else if (pos_q != POS_LAST) begin
				pos_d = pos_q + POS_W'(1);
			end
		end
	end

	assign hdr.dest_mac    = dmac_q;
	assign hdr.source_mac  = smac_q;
	assign hdr.source_ip   = sip_q;
	assign hdr.dest_ip     = dip_q;
	assign hdr.source_port = ports_q[31:16];
	assign hdr.dest_port   = ports_q[15:0];

endmodule

### sv/tcphp_emit.sv
module tcphp_emit import tcphp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  parse_res_t         res,
	input  hdr_t               hdr,
	output logic               ready,
	tcphp_out_if.source        out_ch
);

	// Pending results of the last accepted byte: a first record (header or
	// character) and an end marker that follows it.
	logic       rec_s1;
	logic       is_hdr_s1;
	logic [7:0] pchar_s1;
	logic       end_s1;

	logic      out_valid_q;
	out_beat_t out_q;
	out_beat_t rec_d;
	logic      out_free;
	logic      load;
	logic      one_left;

	assign out_free = !out_valid_q || out_ch.ready;
	assign load     = out_free && (rec_s1 || end_s1);
	assign one_left = rec_s1 ^ end_s1;
	assign ready    = (!rec_s1 && !end_s1) || (one_left && out_free);

	always_comb begin
		rec_d = '0;
		if (rec_s1) begin
			if (is_hdr_s1) begin
				rec_d.record_kind = KIND_HEADER;
				rec_d.dest_mac    = hdr.dest_mac;
				rec_d.source_mac  = hdr.source_mac;
				rec_d.source_ip   = hdr.source_ip;
				rec_d.dest_ip     = hdr.dest_ip;
				rec_d.source_port = hdr.source_port;
				rec_d.dest_port   = hdr.dest_port;
			end else begin
				rec_d.record_kind  = KIND_CHAR;
				rec_d.payload_char = pchar_s1;
			end
		end else begin
			rec_d.record_kind   = KIND_END;
			rec_d.last_of_frame = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_s1      <= 1'b0;
			is_hdr_s1   <= 1'b0;
			pchar_s1    <= '0;
			end_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (fire) begin
				rec_s1    <= res.hdr || res.chr;
				is_hdr_s1 <= res.hdr;
				pchar_s1  <= res.pchar;
				end_s1    <= res.eom;
			end else if (load) begin
				if (rec_s1) begin
					rec_s1 <= 1'b0;
				end else begin
					end_s1 <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
				out_q       <= rec_d;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

### sv/tcp_header_parser_payload_filter_top.sv
// Channel   Direction  Beat contents
// in_ch     sink       data_byte, end_of_frame (one frame byte per beat)
// out_ch    source     record_kind, MACs, IPs, ports, payload_char, last_of_frame
// cfg       write      cfg_we, cfg_index, cfg_data (no read-back)
//
// One frame byte is accepted per cycle while in_ch.ready is high. A byte is
// parsed in the cycle it is accepted; its results sit in a small pending
// stage and then leave through the output register. A byte that causes two
// results (header and end marker, or a payload character and end marker)
// holds in_ch.ready low while both results are pending, since the single
// output register passes at most one result per cycle.
// Reset clears the parse state and sets the registers to their defaults.
// A stall on out_ch fills the pending stage and then lowers in_ch.ready.
module tcp_header_parser_payload_filter_top import tcphp_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tcphp_in_if.sink              in_ch,
	tcphp_out_if.source           out_ch
);

	// Configuration registers. Writes are expected only while the block is
	// idle; an index beyond the three registers is ignored.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.payload_limit <= RST_PAYLOAD_LIMIT;
			cfg_q.watch_port_a  <= RST_WATCH_PORT_A;
			cfg_q.watch_port_b  <= RST_WATCH_PORT_B;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAYLOAD_LIMIT: cfg_q.payload_limit <= cfg_data[7:0];
				REG_WATCH_PORT_A:  cfg_q.watch_port_a  <= cfg_data;
				REG_WATCH_PORT_B:  cfg_q.watch_port_b  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A beat is taken whenever the pending stage will be free at the edge.
	logic       in_rdy;
	logic       fire;
	parse_res_t res;
	hdr_t       hdr;

	assign in_ch.ready = in_rdy;
	assign fire        = in_ch.valid && in_rdy;

	// The parser tracks the byte position and captures the header fields.
	tcphp_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (in_ch.data),
		.cfg    (cfg_q),
		.res    (res),
		.hdr    (hdr)
	);

	// The emitter serialises the results of each byte onto out_ch.
	tcphp_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.res    (res),
		.hdr    (hdr),
		.ready  (in_rdy),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	// A byte closes its headers or carries payload, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !(res.hdr && res.chr))
		else $error("header and payload character from one byte");

	// Without an accepted beat the parser reports nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire |-> !(res.hdr || res.chr || res.eom))
		else $error("parse result without an accepted beat");

	// Payload characters leave masked to the printable range or a dot.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.record_kind == KIND_CHAR) |->
		((out_ch.data.payload_char >= CHAR_LO && out_ch.data.payload_char <= CHAR_HI)
		|| out_ch.data.payload_char == CHAR_DOT))
		else $error("unmasked payload character");

	// The end flag rides on end markers and on nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |->
		(out_ch.data.last_of_frame == (out_ch.data.record_kind == KIND_END)))
		else $error("end flag does not match the record kind");
`endif

endmodule

### dv/tb_tcp_header_parser_payload_filter_top.sv
module tb_tcp_header_parser_payload_filter_top import tcphp_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_FRAME_BYTES = 2048;

	// The register file has three entries; the fourth index must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// A byte reaches the output through the pending stage and then the output
	// register, and bytes that yield nothing may still be in flight when the
	// record queue empties, so a short settle time is allowed before any write.
	localparam int SETTLE_CYCLES = 12;

	// No beat on either channel for this many cycles means the block hung.
	// The longest legal silence is a sender gap plus a receiver stall plus a
	// configuration pause.
	localparam int WATCHDOG_LIMIT = 4000;

	// Random traffic is split into phases, each under its own settings.
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_BYTES   = 50;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	tcphp_in_if  in_ch ();
	tcphp_out_if out_ch ();

	tcp_header_parser_payload_filter_top #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Frame bytes waiting to be offered, and the records that the accepted
	// bytes are known to produce, oldest first.
	in_beat_t  pending_bytes[$];
	out_beat_t expected_records[$];
	int        queued_bytes = 0;
	int        errors = 0;
	int        idle_cycles = 0;
	bit        in_taken = 1'b0;

	// Our own copy of the register file, updated as each write goes out.
	cfg_t shadow_cfg;

	// Parser state as the block should hold it.
	logic [10:0] pos;
	phase_t      phase;
	logic [7:0]  eth_hi;
	logic [5:0]  ip_hdr_len;
	logic [5:0]  tcp_hdr_len;
	logic [47:0] mac_d;
	logic [47:0] mac_s;
	logic [31:0] ip_s;
	logic [31:0] ip_d;
	logic [31:0] ports;
	logic [7:0]  char_count;

	// Sender and receiver pacing.
	int          burst_left = 0;
	int          gap_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int          pattern_age = 0;

	// Works out what one accepted frame byte produces and queues it. The
	// header fields are shifted in while headers are being parsed; once the
	// last TCP header byte is seen the frame switches to payload, where each
	// byte may become one masked character on a watched port.
	task automatic parse_frame_byte(input in_beat_t beat);
		int         p;
		int         t;
		logic [7:0] b;
		out_beat_t  rec;
		p = int'(pos);
		b = beat.data_byte;
		if (phase == PH_HEADERS) begin
			if (p < 6) begin
				mac_d = {mac_d[39:0], b};
			end else if (p < 12) begin
				mac_s = {mac_s[39:0], b};
			end else if (p == 12) begin
				eth_hi = b;
			end else if (p == 13) begin
				if ({eth_hi, b} != ETH_TYPE_IPV4)
					phase = PH_REJECT;
			end else if (p == 14) begin
				if (b[3:0] < MIN_HDR_WORDS)
					phase = PH_REJECT;
				else
					ip_hdr_len = {b[3:0], 2'b00};
			end else if (p == 23) begin
				if (b != IP_PROTO_TCP)
					phase = PH_REJECT;
			end else if (p >= 26 && p < 30) begin
				ip_s = {ip_s[23:0], b};
			end else if (p >= 30 && p < 34) begin
				ip_d = {ip_d[23:0], b};
			end
			if (phase == PH_HEADERS && p >= 34 && ip_hdr_len != 0) begin
				t = ETH_HDR_BYTES + int'(ip_hdr_len);
				if (p >= t && p < t + 4) begin
					ports = {ports[23:0], b};
				end else if (p == t + 12) begin
					if (b[7:4] < MIN_HDR_WORDS)
						phase = PH_REJECT;
					else
						tcp_hdr_len = {b[7:4], 2'b00};
				end else if (tcp_hdr_len != 0 && p == t + int'(tcp_hdr_len) - 1) begin
					rec = '0;
					rec.record_kind = KIND_HEADER;
					rec.dest_mac    = mac_d;
					rec.source_mac  = mac_s;
					rec.source_ip   = ip_s;
					rec.dest_ip     = ip_d;
					rec.source_port = ports[31:16];
					rec.dest_port   = ports[15:0];
					expected_records.push_back(rec);
					phase = PH_PAYLOAD;
				end
			end
			// Headers still open when the position saturates: give up.
			if (phase == PH_HEADERS && p >= MAX_FRAME_BYTES - 1)
				phase = PH_REJECT;
		end else if (phase == PH_PAYLOAD) begin
			if ((ports[15:0] == shadow_cfg.watch_port_a ||
			     ports[15:0] == shadow_cfg.watch_port_b) &&
			    char_count < shadow_cfg.payload_limit) begin
				rec = '0;
				rec.record_kind  = KIND_CHAR;
				rec.payload_char = (b >= CHAR_LO && b <= CHAR_HI) ? b : CHAR_DOT;
				expected_records.push_back(rec);
				char_count = char_count + 8'd1;
			end
		end
		if (beat.end_of_frame) begin
			if (phase == PH_PAYLOAD) begin
				rec = '0;
				rec.record_kind   = KIND_END;
				rec.last_of_frame = 1'b1;
				expected_records.push_back(rec);
			end
			pos         = '0;
			phase       = PH_HEADERS;
			eth_hi      = '0;
			ip_hdr_len  = '0;
			tcp_hdr_len = '0;
			char_count  = '0;
		end else if (p < MAX_FRAME_BYTES - 1) begin
			pos = pos + 11'd1;
		end
	endtask

	task automatic compare_field(input string name, input logic [47:0] want,
		input logic [47:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	task automatic check_record(input out_beat_t got);
		out_beat_t want;
		if (expected_records.size() == 0) begin
			$error("record_kind %0d arrived with no record expected", got.record_kind);
			errors++;
		end else begin
			want = expected_records.pop_front();
			compare_field("record_kind", want.record_kind, got.record_kind);
			compare_field("dest_mac", want.dest_mac, got.dest_mac);
			compare_field("source_mac", want.source_mac, got.source_mac);
			compare_field("source_ip", want.source_ip, got.source_ip);
			compare_field("dest_ip", want.dest_ip, got.dest_ip);
			compare_field("source_port", want.source_port, got.source_port);
			compare_field("dest_port", want.dest_port, got.dest_port);
			compare_field("payload_char", want.payload_char, got.payload_char);
			compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
		end
	endtask

	// Everything is sampled on the rising edge, before the block's own
	// registers move. An accepted input beat is run through the predictor
	// straight away, so its records are queued before any can come out.
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				in_taken = 1'b1;
				parse_frame_byte(in_ch.data);
			end
			if (out_ch.valid && out_ch.ready)
				check_record(out_ch.data);
			if (in_taken || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$error("no beat accepted for %0d cycles, %0d records outstanding",
					idle_cycles, expected_records.size());
				$display("** tcp_header_parser_payload_filter_top: FAILED **");
				$finish;
			end
		end
	end

	// Sender. It offers beats in bursts of random length separated by random
	// gaps; some gaps are zero so that long unbroken runs occur as well. A
	// beat once offered is held until the block takes it.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken)
				void'(pending_bytes.pop_front());
			if (in_ch.valid && !in_taken) begin
				// Still waiting for the block to take the current beat.
			end else if (gap_left != 0) begin
				gap_left--;
				in_ch.valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= pending_bytes[0];
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
					                                         : $urandom_range(1, 20);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver. Ready follows a rotating 16-bit pattern that is redrawn now
	// and then; one pattern in four is all ones, so there are stretches with
	// no back-pressure. Bit zero is always set, so a stall always ends before
	// the pattern comes round again.
	always @(negedge clk) begin
		if (pattern_age == 0) begin
			pattern_age   = $urandom_range(16, 96);
			ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
			                                            : (16'($urandom) | 16'h0001);
		end else begin
			pattern_age--;
			ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
		end
		out_ch.ready <= ready_pattern[0];
	end

	task automatic push_byte(input logic [7:0] b, input logic last);
		in_beat_t beat;
		beat.data_byte    = b;
		beat.end_of_frame = last;
		pending_bytes.push_back(beat);
		queued_bytes++;
	endtask

	// Builds one frame: random MACs, addresses and filler, the fixed fields
	// as asked, and a payload biased towards printable bytes and the edges
	// of the printable range. A header length below the minimum still lays
	// out the usual 20 bytes, since the block stops looking at it anyway.
	// keep, if non-zero, cuts the frame short after that many bytes.
	task automatic queue_frame(input logic [15:0] ethtype, input logic [7:0] proto,
		input logic [3:0] ihl, input logic [3:0] doff, input logic [15:0] dport,
		input int paylen, input int keep);
		int          tcp_at;
		int          payload_at;
		int          total;
		int          i;
		logic [15:0] sport;
		logic [7:0]  b;
		sport      = 16'($urandom);
		tcp_at     = ETH_HDR_BYTES + 4 * ((ihl < MIN_HDR_WORDS) ? 5 : int'(ihl));
		payload_at = tcp_at + 4 * ((doff < MIN_HDR_WORDS) ? 5 : int'(doff));
		total      = payload_at + paylen;
		if (keep > 0 && keep < total)
			total = keep;
		for (i = 0; i < total; i++) begin
			b = 8'($urandom);
			if (i == 12) begin
				b = ethtype[15:8];
			end else if (i == 13) begin
				b = ethtype[7:0];
			end else if (i == 14) begin
				b = {b[7:4], ihl};
			end else if (i == 23) begin
				b = proto;
			end else if (i == tcp_at) begin
				b = sport[15:8];
			end else if (i == tcp_at + 1) begin
				b = sport[7:0];
			end else if (i == tcp_at + 2) begin
				b = dport[15:8];
			end else if (i == tcp_at + 3) begin
				b = dport[7:0];
			end else if (i == tcp_at + 12) begin
				b = {doff, b[3:0]};
			end else if (i >= payload_at) begin
				case ($urandom_range(0, 3))
					0: b = 8'($urandom_range(32, 126));
					1: begin
						case ($urandom_range(0, 5))
							0: b = 8'd0;
							1: b = CHAR_LO - 8'd1;
							2: b = CHAR_LO;
							3: b = CHAR_HI;
							4: b = CHAR_HI + 8'd1;
							default: b = 8'hFF;
						endcase
					end
					default: ;
				endcase
			end
			push_byte(b, i == total - 1);
		end
	endtask

	// Mostly well-formed TCP frames with random content, aimed at the watched
	// ports two times in three; the rest are cut short, carry a near-miss or
	// random ethertype, a near-miss protocol, a header length under the
	// minimum, or are plain noise.
	task automatic queue_random_frame();
		int          pick;
		int          paylen;
		int          i;
		int          n;
		logic [3:0]  ihl;
		logic [3:0]  doff;
		logic [15:0] dport;
		logic [15:0] ethtype;
		logic [7:0]  proto;
		ihl     = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom_range(5, 15));
		doff    = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom_range(5, 15));
		paylen  = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 40) : $urandom_range(41, 160);
		ethtype = ETH_TYPE_IPV4;
		proto   = IP_PROTO_TCP;
		case ($urandom_range(0, 2))
			0: dport = shadow_cfg.watch_port_a;
			1: dport = shadow_cfg.watch_port_b;
			default: dport = 16'($urandom);
		endcase
		pick = $urandom_range(0, 9);
		if (pick == 7) begin
			if ($urandom_range(0, 1) != 0)
				ethtype = ($urandom_range(0, 3) == 0) ? 16'($urandom)
				                                      : ETH_TYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
			else
				proto = IP_PROTO_TCP ^ (8'd1 << $urandom_range(0, 7));
		end else if (pick == 8) begin
			if ($urandom_range(0, 1) != 0)
				ihl = 4'($urandom_range(0, 4));
			else
				doff = 4'($urandom_range(0, 4));
		end
		if (pick == 9) begin
			n = $urandom_range(1, 30);
			for (i = 0; i < n; i++)
				push_byte(8'($urandom), i == n - 1);
		end else begin
			// Cut frames stop somewhere before even the shortest header ends.
			queue_frame(ethtype, proto, ihl, doff, dport, paylen,
				(pick == 6) ? $urandom_range(1, 53) : 0);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PAYLOAD_LIMIT: shadow_cfg.payload_limit = value[7:0];
			REG_WATCH_PORT_A:  shadow_cfg.watch_port_a  = value;
			REG_WATCH_PORT_B:  shadow_cfg.watch_port_b  = value;
			default: ;
		endcase
	endtask

	// Waits until every byte has gone in and every record has come out,
	// then lets the pipeline settle so that nothing is still in flight.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_ch.valid || expected_records.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int          phase_idx;
		int          start_count;
		logic [7:0]  limit;
		logic [15:0] port_a;
		logic [15:0] port_b;

		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;

		shadow_cfg.payload_limit = RST_PAYLOAD_LIMIT;
		shadow_cfg.watch_port_a  = RST_WATCH_PORT_A;
		shadow_cfg.watch_port_b  = RST_WATCH_PORT_B;
		pos         = '0;
		phase       = PH_HEADERS;
		eth_hi      = '0;
		ip_hdr_len  = '0;
		tcp_hdr_len = '0;
		mac_d       = '0;
		mac_s       = '0;
		ip_s        = '0;
		ip_d        = '0;
		ports       = '0;
		char_count  = '0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset settings. A watched frame whose
		// final byte is payload, one whose header ends on its final byte,
		// then each way a frame can be rejected or cut short, the largest
		// header lengths, and an unwatched port. Rejected frames end a few
		// bytes after the field that rejects them.
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, RST_WATCH_PORT_A, 16, 0);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, RST_WATCH_PORT_B, 0, 0);
		queue_frame(16'h0806, IP_PROTO_TCP, 4'd5, 4'd5, RST_WATCH_PORT_A, 0, 20);
		queue_frame(ETH_TYPE_IPV4, 8'd17, 4'd5, 4'd5, RST_WATCH_PORT_A, 0, 30);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd4, 4'd5, RST_WATCH_PORT_A, 0, 20);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd0, 4'd5, RST_WATCH_PORT_A, 0, 20);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd4, RST_WATCH_PORT_A, 0, 50);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd15, 4'd15, RST_WATCH_PORT_A, 6, 0);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, 16'd22, 4, 0);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, RST_WATCH_PORT_A, 10, 40);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, RST_WATCH_PORT_A, 10, 53);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, RST_WATCH_PORT_A, 10, 1);

		// Limit of zero and the extreme port numbers; the write to the spare
		// index must leave all three registers alone.
		wait_drained();
		write_reg(REG_PAYLOAD_LIMIT, 16'hFF00);
		write_reg(REG_WATCH_PORT_A, 16'h0000);
		write_reg(REG_WATCH_PORT_B, 16'hFFFF);
		write_reg(REG_SPARE, 16'($urandom));
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, 16'h0000, 4, 0);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, 16'hFFFF, 4, 0);

		// Largest limit, with a payload that stays under it.
		wait_drained();
		write_reg(REG_PAYLOAD_LIMIT, 16'hFFFF);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, 16'hFFFF, 20, 0);

		// A limit of one.
		wait_drained();
		write_reg(REG_PAYLOAD_LIMIT, 16'd1);
		queue_frame(ETH_TYPE_IPV4, IP_PROTO_TCP, 4'd5, 4'd5, 16'h0000, 5, 0);

		// Random traffic, each phase under fresh settings. The upper byte of
		// the limit write is random, so its masking gets exercised too.
		for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
			wait_drained();
			case ($urandom_range(0, 5))
				0: limit = 8'd0;
				1: limit = 8'd1;
				2: limit = 8'hFF;
				default: limit = 8'($urandom_range(2, 60));
			endcase
			port_a = ($urandom_range(0, 4) == 0) ? 16'h0000 : 16'($urandom);
			port_b = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
			write_reg(REG_PAYLOAD_LIMIT, {8'($urandom), limit});
			write_reg(REG_WATCH_PORT_A, port_a);
			write_reg(REG_WATCH_PORT_B, port_b);
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_SPARE, 16'($urandom));
			start_count = queued_bytes;
			while (queued_bytes - start_count < PHASE_BYTES)
				queue_random_frame();
		end

		wait_drained();
		if (expected_records.size() != 0) begin
			$error("%0d records never arrived", expected_records.size());
			errors++;
		end
		if (errors == 0)
			$display("** tcp_header_parser_payload_filter_top: PASSED **");
		else
			$display("** tcp_header_parser_payload_filter_top: FAILED **");
		$finish;
	end

endmodule
